### sv/sorted_priority_list_unit_macros.svh
// Assertion macros shared by the sorted priority list RTL.
`ifndef SORTED_PRIORITY_LIST_UNIT_MACROS_SVH
`define SORTED_PRIORITY_LIST_UNIT_MACROS_SVH

// Clocked check, off while reset is asserted.
`define SPL_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("spl: assertion failed");

// Clocked check that also holds across reset.
`define SPL_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("spl: assertion failed");

`endif

### sv/spl_pkg.sv
// Package with types, codes and constants of the sorted priority list.
`timescale 1ns / 1ps
package spl_pkg;

    localparam int DEF_CAPACITY = 16;
    localparam int ID_W         = 16;
    localparam int KEY_W        = 32;
    localparam int CNT_OUT_W    = 5;
    localparam int ENTRY_W      = ID_W + KEY_W;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_POP    = 2'd1,
        ACT_PEEK   = 2'd2,
        ACT_SEARCH = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_HEAD_RD,
        S_HEAD_CAP,
        S_POP_RD,
        S_POP_WR,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_COUNT,
        IDX_ZERO,
        IDX_INC,
        IDX_DEC
    } t_idx_op;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_CUR,
        RD_PREV
    } t_rd_op;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_NEW,
        WR_SHIFT_UP,
        WR_SHIFT_DOWN
    } t_wr_op;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } t_cnt_op;

    typedef enum logic [2:0] {
        RES_NONE,
        RES_OK,
        RES_FULL,
        RES_EMPTY,
        RES_NOT_FOUND,
        RES_HEAD,
        RES_FOUND
    } t_res_op;

    typedef struct packed {
        logic    capture;
        t_idx_op idx_op;
        t_rd_op  rd_op;
        t_wr_op  wr_op;
        t_cnt_op cnt_op;
        t_res_op res_op;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        logic count_zero;
        logic count_full;
        logic idx_zero;
        logic idx_at_count;
        logic key_ge;
        logic id_match;
        logic op_is_pop;
    } t_stat;

endpackage

### sv/sorted_priority_list_unit.sv
// Sorted priority list (id, key) entries in descending key order: top level.
//
// Input channel: i_valid / o_ready with i_action, i_entry_id, i_entry_key.
// Output channel: o_valid / i_ready with o_status, o_out_id, o_out_key,
// o_entry_count. Every input transfer gives exactly one output transfer.
// Entries live in a single-port-write, single-port-read memory of CAPACITY
// words; one controller walks it one entry at a time, a read step then a
// compare or write step per entry. Steps per action:
//   insert:  from the tail, each entry with a key not above the new key moves
//            down one place; the new entry is then written into the opened slot
//   pop:     head read, then each entry moved up one place
//   peek:    head read
//   search:  entries read from the head until the id matches or the list ends
//   full insert, empty pop/peek, empty search: straight to the result, no memory access
// One item is in work at a time; o_ready is high only while idle.
// The result sits in an output register, so the next item is taken while a
// result still waits; if the receiver stalls, the following result holds
// inside the block until the output register frees.
// Reset (i_rst_n low at a clock edge) empties the list and drops any
// pending result; memory contents need no clearing.
`timescale 1ns / 1ps
module sorted_priority_list_unit #(
    parameter int CAPACITY = spl_pkg::DEF_CAPACITY
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  spl_pkg::t_action                    i_action,
    input  logic [spl_pkg::ID_W-1:0]            i_entry_id,
    input  logic signed [spl_pkg::KEY_W-1:0]    i_entry_key,
    output logic                                o_valid,
    input  logic                                i_ready,
    output spl_pkg::t_status                    o_status,
    output logic [spl_pkg::ID_W-1:0]            o_out_id,
    output logic signed [spl_pkg::KEY_W-1:0]    o_out_key,
    output logic [spl_pkg::CNT_OUT_W-1:0]       o_entry_count
);
    import spl_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    spl_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_action (i_action),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_stat   (w_stat),
        .o_cmd    (w_cmd)
    );

    spl_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_action      (i_action),
        .i_entry_id    (i_entry_id),
        .i_entry_key   (i_entry_key),
        .o_status      (o_status),
        .o_out_id      (o_out_id),
        .o_out_key     (o_out_key),
        .o_entry_count (o_entry_count)
    );

endmodule

### sv/spl_dpath.sv
// Datapath of the sorted priority list: entry memory, index, count, result registers.
`timescale 1ns / 1ps
module spl_dpath #(
    parameter int CAPACITY = spl_pkg::DEF_CAPACITY
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  spl_pkg::t_cmd                       i_cmd,
    output spl_pkg::t_stat                      o_stat,
    input  spl_pkg::t_action                    i_action,
    input  logic [spl_pkg::ID_W-1:0]            i_entry_id,
    input  logic signed [spl_pkg::KEY_W-1:0]    i_entry_key,
    output spl_pkg::t_status                    o_status,
    output logic [spl_pkg::ID_W-1:0]            o_out_id,
    output logic signed [spl_pkg::KEY_W-1:0]    o_out_key,
    output logic [spl_pkg::CNT_OUT_W-1:0]       o_entry_count
);
    import spl_pkg::*;
    `include "sorted_priority_list_unit_macros.svh"

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    t_action                   r_op;
    logic [ID_W-1:0]           r_new_id;
    logic signed [KEY_W-1:0]   r_new_key;
    logic [CNT_W-1:0]          r_idx;
    logic [CNT_W-1:0]          n_idx;
    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          n_count;
    logic [ENTRY_W-1:0]        r_mem [CAPACITY];
    logic [ENTRY_W-1:0]        r_rd_data;
    logic [CNT_W-1:0]          w_idx_m1;
    logic [CNT_W-1:0]          w_rd_full;
    logic [CNT_W-1:0]          w_wr_full;
    logic [IDX_W-1:0]          w_rd_addr;
    logic [IDX_W-1:0]          w_wr_addr;
    logic [ENTRY_W-1:0]        w_wr_data;
    logic [ID_W-1:0]           w_rd_id;
    logic signed [KEY_W-1:0]   w_rd_key;
    t_status                   r_res_status;
    t_status                   n_res_status;
    logic [ID_W-1:0]           r_res_id;
    logic [ID_W-1:0]           n_res_id;
    logic signed [KEY_W-1:0]   r_res_key;
    logic signed [KEY_W-1:0]   n_res_key;
    t_status                   r_out_status;
    logic [ID_W-1:0]           r_out_id;
    logic signed [KEY_W-1:0]   r_out_key;
    logic [CNT_OUT_W-1:0]      r_out_count;
    logic [CNT_W+CNT_OUT_W-1:0] w_cnt_ext;

    assign w_idx_m1  = r_idx - 1'b1;
    assign w_rd_id   = r_rd_data[KEY_W +: ID_W];
    assign w_rd_key  = $signed(r_rd_data[KEY_W-1:0]);
    assign w_cnt_ext = {{CNT_OUT_W{1'b0}}, r_count};

    always_comb begin
        unique case (i_cmd.rd_op)
            RD_PREV: w_rd_full = w_idx_m1;
            default: w_rd_full = r_idx;
        endcase
        unique case (i_cmd.wr_op)
            WR_SHIFT_DOWN: w_wr_full = w_idx_m1;
            default:       w_wr_full = r_idx;
        endcase
        unique case (i_cmd.wr_op)
            WR_NEW:  w_wr_data = {r_new_id, r_new_key};
            default: w_wr_data = r_rd_data;
        endcase
    end

    assign w_rd_addr = w_rd_full[IDX_W-1:0];
    assign w_wr_addr = w_wr_full[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_op != WR_NONE) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (i_cmd.rd_op != RD_NONE) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    always_comb begin
        unique case (i_cmd.idx_op)
            IDX_COUNT: n_idx = r_count;
            IDX_ZERO:  n_idx = '0;
            IDX_INC:   n_idx = r_idx + 1'b1;
            IDX_DEC:   n_idx = w_idx_m1;
            default:   n_idx = r_idx;
        endcase
        unique case (i_cmd.cnt_op)
            CNT_INC: n_count = r_count + 1'b1;
            CNT_DEC: n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_comb begin
        n_res_status = r_res_status;
        n_res_id     = r_res_id;
        n_res_key    = r_res_key;
        unique case (i_cmd.res_op)
            RES_OK: begin
                n_res_status = ST_OK;
                n_res_id     = '0;
                n_res_key    = '0;
            end
            RES_FULL: begin
                n_res_status = ST_FULL;
                n_res_id     = '0;
                n_res_key    = '0;
            end
            RES_EMPTY: begin
                n_res_status = ST_EMPTY;
                n_res_id     = '0;
                n_res_key    = '0;
            end
            RES_NOT_FOUND: begin
                n_res_status = ST_NOT_FOUND;
                n_res_id     = '0;
                n_res_key    = '0;
            end
            RES_HEAD: begin
                n_res_status = ST_OK;
                n_res_id     = w_rd_id;
                n_res_key    = w_rd_key;
            end
            RES_FOUND: begin
                n_res_status = ST_OK;
                n_res_id     = '0;
                n_res_key    = w_rd_key;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_res_status <= n_res_status;
        r_res_id     <= n_res_id;
        r_res_key    <= n_res_key;
        if (i_cmd.capture) begin
            r_op      <= i_action;
            r_new_id  <= i_entry_id;
            r_new_key <= i_entry_key;
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_id     <= r_res_id;
            r_out_key    <= r_res_key;
            r_out_count  <= w_cnt_ext[CNT_OUT_W-1:0];
        end
    end

    assign o_stat.count_zero   = (r_count == '0);
    assign o_stat.count_full   = (r_count == CNT_W'(CAPACITY));
    assign o_stat.idx_zero     = (r_idx == '0);
    assign o_stat.idx_at_count = (r_idx == r_count);
    assign o_stat.key_ge       = (r_new_key >= w_rd_key);
    assign o_stat.id_match     = (w_rd_id == r_new_id);
    assign o_stat.op_is_pop    = (r_op == ACT_POP);

    assign o_status      = r_out_status;
    assign o_out_id      = r_out_id;
    assign o_out_key     = r_out_key;
    assign o_entry_count = r_out_count;

    `SPL_ASSERT(a_count_le_cap, i_clk, i_rst_n, r_count <= CNT_W'(CAPACITY))
    `SPL_ASSERT(a_inc_not_full, i_clk, i_rst_n, (i_cmd.cnt_op == CNT_INC) |-> !o_stat.count_full)
    `SPL_ASSERT(a_wr_in_range, i_clk, i_rst_n, (i_cmd.wr_op != WR_NONE) |-> (w_wr_full < CNT_W'(CAPACITY)))

endmodule

### sv/spl_ctrl.sv
// Controller state machine of the sorted priority list.
`timescale 1ns / 1ps
module spl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  spl_pkg::t_action  i_action,
    output logic              o_valid,
    input  logic              i_ready,
    input  spl_pkg::t_stat    i_stat,
    output spl_pkg::t_cmd     o_cmd
);
    import spl_pkg::*;
    `include "sorted_priority_list_unit_macros.svh"

    t_state r_state;
    t_state n_state;
    logic   r_valid;
    logic   n_valid;
    logic   w_slot_free;

    assign w_slot_free = !r_valid || i_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    unique case (i_action)
                        ACT_INSERT: n_state = i_stat.count_full ? S_DONE : S_INS_RD;
                        ACT_SEARCH: n_state = i_stat.count_zero ? S_DONE : S_SRCH_RD;
                        default:    n_state = i_stat.count_zero ? S_DONE : S_HEAD_RD;
                    endcase
                end
            end
            S_INS_RD:   n_state = i_stat.idx_zero ? S_DONE : S_INS_CMP;
            S_INS_CMP:  n_state = i_stat.key_ge ? S_INS_RD : S_DONE;
            S_HEAD_RD:  n_state = S_HEAD_CAP;
            S_HEAD_CAP: n_state = i_stat.op_is_pop ? S_POP_RD : S_DONE;
            S_POP_RD:   n_state = i_stat.idx_at_count ? S_DONE : S_POP_WR;
            S_POP_WR:   n_state = S_POP_RD;
            S_SRCH_RD:  n_state = i_stat.idx_at_count ? S_DONE : S_SRCH_CMP;
            S_SRCH_CMP: n_state = i_stat.id_match ? S_DONE : S_SRCH_RD;
            S_DONE:     n_state = w_slot_free ? S_IDLE : S_DONE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.capture  = 1'b0;
        o_cmd.idx_op   = IDX_HOLD;
        o_cmd.rd_op    = RD_NONE;
        o_cmd.wr_op    = WR_NONE;
        o_cmd.cnt_op   = CNT_HOLD;
        o_cmd.res_op   = RES_NONE;
        o_cmd.out_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    unique case (i_action)
                        ACT_INSERT: begin
                            if (i_stat.count_full) begin
                                o_cmd.res_op = RES_FULL;
                            end else begin
                                o_cmd.idx_op = IDX_COUNT;
                            end
                        end
                        ACT_SEARCH: begin
                            if (i_stat.count_zero) begin
                                o_cmd.res_op = RES_NOT_FOUND;
                            end else begin
                                o_cmd.idx_op = IDX_ZERO;
                            end
                        end
                        default: begin
                            if (i_stat.count_zero) begin
                                o_cmd.res_op = RES_EMPTY;
                            end else begin
                                o_cmd.idx_op = IDX_ZERO;
                            end
                        end
                    endcase
                end
            end
            S_INS_RD: begin
                if (i_stat.idx_zero) begin
                    o_cmd.wr_op  = WR_NEW;
                    o_cmd.cnt_op = CNT_INC;
                    o_cmd.res_op = RES_OK;
                end else begin
                    o_cmd.rd_op = RD_PREV;
                end
            end
            S_INS_CMP: begin
                if (i_stat.key_ge) begin
                    o_cmd.wr_op  = WR_SHIFT_UP;
                    o_cmd.idx_op = IDX_DEC;
                end else begin
                    o_cmd.wr_op  = WR_NEW;
                    o_cmd.cnt_op = CNT_INC;
                    o_cmd.res_op = RES_OK;
                end
            end
            S_HEAD_RD: begin
                o_cmd.rd_op = RD_CUR;
            end
            S_HEAD_CAP: begin
                o_cmd.res_op = RES_HEAD;
                o_cmd.idx_op = IDX_INC;
            end
            S_POP_RD: begin
                if (i_stat.idx_at_count) begin
                    o_cmd.cnt_op = CNT_DEC;
                end else begin
                    o_cmd.rd_op = RD_CUR;
                end
            end
            S_POP_WR: begin
                o_cmd.wr_op  = WR_SHIFT_DOWN;
                o_cmd.idx_op = IDX_INC;
            end
            S_SRCH_RD: begin
                if (i_stat.idx_at_count) begin
                    o_cmd.res_op = RES_NOT_FOUND;
                end else begin
                    o_cmd.rd_op = RD_CUR;
                end
            end
            S_SRCH_CMP: begin
                if (i_stat.id_match) begin
                    o_cmd.res_op = RES_FOUND;
                end else begin
                    o_cmd.idx_op = IDX_INC;
                end
            end
            S_DONE: begin
                o_cmd.out_load = w_slot_free;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_valid;

    `SPL_ASSERT(a_load_slot_free, i_clk, i_rst_n, o_cmd.out_load |-> (!r_valid || i_ready))
    `SPL_ASSERT(a_cmp_after_rd, i_clk, i_rst_n, (r_state == S_INS_CMP) |-> ($past(r_state) == S_INS_RD))
    `SPL_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> (!r_valid && (r_state == S_IDLE)))

endmodule
